>>> sv/ofe_pkg.sv
// shared types and constants for the offset base64 frame encoder
`default_nettype none

package ofe_pkg;

  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned MAX_RESULTS = 7;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [CHAR_W-1:0] ENC_BASE = 7'd61;
  localparam logic [CHAR_W-1:0] CR_CHAR  = 7'd13;

  typedef enum logic [1:0] {
    OP_PREFIX  = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_FINISH  = 2'd2
  } op_t;

  // characters produced by one request, slot 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]                   cnt;
    logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;
    logic [MAX_RESULTS-1:0]             lasts;
  } burst_word_t;

endpackage

`default_nettype wire

>>> sv/ofe_encode.sv
// frame state and per-request character generation
`default_nettype none

module ofe_encode (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [1:0]          op,
  input  logic [7:0]          data,
  output ofe_pkg::burst_word_t word
);
  import ofe_pkg::*;

  logic [11:0] checksum_sum, checksum_sum_next;
  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  group_count, group_count_next;

  logic [7:0]        byte_a, byte_b, byte_c;
  logic [CHAR_W-1:0] g0, g1, g2, g3;
  logic [8:0]        group_sum;
  logic [11:0]       sum_with_group, chk;
  logic [CHAR_W-1:0] chk_hi, chk_lo;
  logic              has_group;

  assign byte_a = held_bytes[15:8];
  assign byte_b = held_bytes[7:0];
  assign byte_c = (op == OP_PAYLOAD) ? data : 8'h00;

  // four 6-bit slices of the group, msb first
  assign g0 = ENC_BASE + {1'b0, byte_a[7:2]};
  assign g1 = ENC_BASE + {1'b0, byte_a[1:0], byte_b[7:4]};
  assign g2 = ENC_BASE + {1'b0, byte_b[3:0], byte_c[7:6]};
  assign g3 = ENC_BASE + {1'b0, byte_c[5:0]};

  assign group_sum      = {2'b00, g0} + {2'b00, g1} + {2'b00, g2} + {2'b00, g3};
  assign sum_with_group = checksum_sum + {3'b000, group_sum};
  assign has_group      = (group_count != 2'd0);
  assign chk            = has_group ? sum_with_group : checksum_sum;
  assign chk_hi         = ENC_BASE + {1'b0, chk[11:6]};
  assign chk_lo         = ENC_BASE + {1'b0, chk[5:0]};

  always_comb begin
    word              = '0;
    checksum_sum_next = checksum_sum;
    held_bytes_next   = held_bytes;
    group_count_next  = group_count;
    unique case (op)
      OP_PREFIX: begin
        word.cnt          = CNT_W'(1);
        word.chars[0]     = data[6:0];
        checksum_sum_next = checksum_sum + {5'b00000, data[6:0]};
      end
      OP_PAYLOAD: begin
        if (group_count[1]) begin
          word.cnt          = CNT_W'(4);
          word.chars[0]     = g0;
          word.chars[1]     = g1;
          word.chars[2]     = g2;
          word.chars[3]     = g3;
          checksum_sum_next = sum_with_group;
          held_bytes_next   = 16'h0000;
          group_count_next  = 2'd0;
        end else if (group_count == 2'd1) begin
          held_bytes_next  = {held_bytes[15:8], data};
          group_count_next = 2'd2;
        end else begin
          held_bytes_next  = {data, 8'h00};
          group_count_next = 2'd1;
        end
      end
      OP_FINISH: begin
        if (has_group) begin
          // padded partial group, then checksum and terminator
          word.cnt      = CNT_W'(7);
          word.chars[0] = g0;
          word.chars[1] = g1;
          word.chars[2] = g2;
          word.chars[3] = g3;
          word.chars[4] = chk_hi;
          word.chars[5] = chk_lo;
          word.chars[6] = CR_CHAR;
          word.lasts[6] = 1'b1;
        end else begin
          word.cnt      = CNT_W'(3);
          word.chars[0] = chk_hi;
          word.chars[1] = chk_lo;
          word.chars[2] = CR_CHAR;
          word.lasts[2] = 1'b1;
        end
        checksum_sum_next = 12'h000;
        held_bytes_next   = 16'h0000;
        group_count_next  = 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_sum <= 12'h000;
      held_bytes   <= 16'h0000;
      group_count  <= 2'd0;
    end else if (advance) begin
      checksum_sum <= checksum_sum_next;
      held_bytes   <= held_bytes_next;
      group_count  <= group_count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    group_count != 2'd3)
    else $error("group count out of range");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (op == OP_FINISH) |=> (checksum_sum == 12'h000) && (group_count == 2'd0))
    else $error("finish did not clear frame state");
`endif

endmodule

`default_nettype wire

>>> sv/ofe_burst.sv
// result shift register, one character out per cycle while out_ready is high
`default_nettype none

module ofe_burst (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  ofe_pkg::burst_word_t        word,
  output logic                        load_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ofe_pkg::CHAR_W-1:0]  out_char,
  output logic                        last
);
  import ofe_pkg::*;

  logic [CNT_W-1:0]                   cnt;
  logic [MAX_RESULTS-1:0][CHAR_W-1:0] chars;
  logic [MAX_RESULTS-1:0]             lasts;
  logic                               fire;

  assign fire      = out_valid && out_ready;
  assign out_valid = (cnt != '0);
  assign out_char  = chars[0];
  assign last      = lasts[0];
  // room for a new burst when empty or once the current one drains this cycle
  assign load_ok   = (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= word.cnt;
    end else if (fire) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= word.chars;
      lasts <= word.lasts;
    end else if (fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        chars[i] <= chars[i+1];
        lasts[i] <= lasts[i+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready))
    else $error("burst loaded over pending characters");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (cnt == CNT_W'(1)))
    else $error("last flag before end of burst");
`endif

endmodule

`default_nettype wire

>>> sv/offset_base64_frame_encoder_core.sv
// top level of the offset base64 frame encoder with additive checksum
//
//   channel   signals                        direction  carries
//   input     in_valid in_ready op data      in         one request: prefix, payload or finish
//   output    out_valid out_ready out_char   out        up to seven frame characters per request
//             last                                      (last marks the closing carriage return)
//
// a request passes an input register, then one encode step loads up to seven
// characters into the result shift register, which sends one per cycle while out_ready is high
// a request yields one character for a prefix, none for a held payload byte,
// 4 for a full group, 3 or 7 for a finish
// rst is synchronous and clears the frame state, the input register and the count
// out_ready low holds the burst, and the input register then fills and drops in_ready
`default_nettype none

module offset_base64_frame_encoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [7:0]                 data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ofe_pkg::CHAR_W-1:0] out_char,
  output logic                       last
);
  import ofe_pkg::*;

  // input register
  logic        in_full;
  logic [1:0]  op_q;
  logic [7:0]  data_q;

  logic        load_ok;
  logic        advance;
  burst_word_t word;

  // held request moves on when the result register can take its burst
  assign advance  = in_full && load_ok;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op;
      data_q <= data;
    end
  end

  // frame state plus character generation for the held request
  ofe_encode u_encode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .op      (op_q),
    .data    (data_q),
    .word    (word)
  );

  // result register, drains one character a cycle while out_ready is high
  ofe_burst u_burst (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .word      (word),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(op_q) && $stable(data_q))
    else $error("held request lost before encode");
`endif

endmodule

`default_nettype wire

>>> sim/tb_offset_base64_frame_encoder_core.sv
// testbench for the offset base64 frame encoder: directed and random frames against a predictor
module tb_offset_base64_frame_encoder_core;
  import ofe_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RANDOM_TARGET  = 200;
  localparam int DRAIN_CYCLES   = 24;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int PRINT_LIMIT    = 40;

  // op code with no meaning, the block must drop it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              fin;
  } frame_char_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        op = OP_PREFIX;
  logic [7:0]        data = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  // predictor state
  logic [11:0]       frame_sum = '0;
  logic [15:0]       held_bytes = '0;
  logic [1:0]        held_cnt = '0;
  frame_char_t       expected_chars[$];

  int                mismatches = 0;
  int                requests_sent = 0;
  bit                source_idles = 1'b0;
  bit                sink_stalls = 1'b0;
  int                sink_hold = 0;

  offset_base64_frame_encoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .data      (data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report(input string field, input logic [CHAR_W-1:0] want,
                        input logic [CHAR_W-1:0] got);
    if (mismatches < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, want, got);
    end
    mismatches++;
  endtask

  task automatic push_char(input logic [CHAR_W-1:0] ch, input logic fin);
    frame_char_t c;
    c.ch  = ch;
    c.fin = fin;
    expected_chars.push_back(c);
  endtask

  // characters of the frame body count toward the checksum
  task automatic push_counted(input logic [CHAR_W-1:0] ch);
    push_char(ch, 1'b0);
    frame_sum = frame_sum + 12'(ch);
  endtask

  task automatic push_group(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    push_counted(ENC_BASE + 7'(a[7:2]));
    push_counted(ENC_BASE + 7'({a[1:0], b[7:4]}));
    push_counted(ENC_BASE + 7'({b[3:0], c[7:6]}));
    push_counted(ENC_BASE + 7'(c[5:0]));
  endtask

  task automatic encode_request(input logic [1:0] req_op, input logic [7:0] req_data);
    case (req_op)
      OP_PREFIX: begin
        push_counted(req_data[6:0]);
      end
      OP_PAYLOAD: begin
        if (held_cnt == 2'd2) begin
          push_group(held_bytes[15:8], held_bytes[7:0], req_data);
          held_bytes = '0;
          held_cnt   = '0;
        end else if (held_cnt == 2'd1) begin
          held_bytes[7:0] = req_data;
          held_cnt        = 2'd2;
        end else begin
          held_bytes = {req_data, 8'h00};
          held_cnt   = 2'd1;
        end
      end
      OP_FINISH: begin
        // partial group padded with zeros, then checksum digits and carriage return
        if (held_cnt != 2'd0) begin
          push_group(held_bytes[15:8], held_bytes[7:0], 8'h00);
        end
        push_char(ENC_BASE + 7'(frame_sum[11:6]), 1'b0);
        push_char(ENC_BASE + 7'(frame_sum[5:0]), 1'b0);
        push_char(CR_CHAR, 1'b1);
        frame_sum  = '0;
        held_bytes = '0;
        held_cnt   = '0;
      end
      default: begin
      end
    endcase
  endtask

  // one process checks results first, then predicts from the request of the same edge
  always @(posedge clk) begin
    frame_char_t want;
    if (rst) begin
      frame_sum  = '0;
      held_bytes = '0;
      held_cnt   = '0;
      expected_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report("unexpected out_char", '0, out_char);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch) begin
            report("out_char", want.ch, out_char);
          end
          if (last !== want.fin) begin
            report("last", 7'(want.fin), 7'(last));
          end
        end
      end
      if (in_valid && in_ready) begin
        encode_request(op, data);
      end
    end
  end

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int source_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!source_idles || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
      sink_hold = stall_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input logic [1:0] req_op, input logic [7:0] req_data);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= req_op;
    data     <= req_data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req_op != OP_UNUSED) begin
      requests_sent++;
    end
    gap = source_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic set_idling(input int pick);
    source_idles = pick[0];
    sink_stalls  = pick[1];
  endtask

  task automatic test_prefix_chars();
    send_request(OP_PREFIX, 8'h00);
    send_request(OP_PREFIX, 8'h7f);
    send_request(OP_PREFIX, 8'h80);
    send_request(OP_PREFIX, 8'hff);
    send_request(OP_FINISH, 8'h00);
  endtask

  task automatic test_empty_frame();
    send_request(OP_FINISH, 8'hff);
  endtask

  task automatic test_payload_groups();
    send_request(OP_PAYLOAD, 8'h00);
    send_request(OP_PAYLOAD, 8'hff);
    send_request(OP_PAYLOAD, 8'h80);
    send_request(OP_PAYLOAD, 8'ha5);
    send_request(OP_FINISH, 8'h00);
    send_request(OP_PAYLOAD, 8'h5a);
    send_request(OP_PAYLOAD, 8'hc3);
    send_request(OP_FINISH, 8'h00);
  endtask

  task automatic test_prefix_inside_group();
    send_request(OP_PAYLOAD, 8'h3c);
    send_request(OP_PREFIX, 8'h20);
    send_request(OP_PAYLOAD, 8'h0f);
    send_request(OP_PREFIX, 8'hc1);
    send_request(OP_FINISH, 8'h00);
  endtask

  task automatic test_unused_op();
    send_request(OP_UNUSED, 8'hff);
    send_request(OP_PAYLOAD, 8'h12);
    send_request(OP_UNUSED, 8'h00);
    send_request(OP_FINISH, 8'h00);
  endtask

  task automatic well_formed_frame();
    int n_prefix;
    int n_payload;
    n_prefix = $urandom_range(0, 4);
    // a few long frames push the checksum past its wrap
    n_payload = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(20, 60);
    repeat (n_prefix) send_request(OP_PREFIX, 8'($urandom));
    repeat (n_payload) begin
      if ($urandom_range(0, 99) < 8) begin
        send_request(OP_PREFIX, 8'($urandom));
      end
      if ($urandom_range(0, 99) < 4) begin
        send_request(OP_UNUSED, 8'($urandom));
      end
      send_request(OP_PAYLOAD, 8'($urandom));
    end
    // now and then the frame is left open and runs into the next one
    if ($urandom_range(0, 99) < 90) begin
      send_request(OP_FINISH, 8'($urandom));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) send_request(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic test_random_frames();
    int start_count;
    start_count = requests_sent;
    while (requests_sent - start_count < RANDOM_TARGET) begin
      set_idling($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 10) begin
        noise_burst();
      end else begin
        well_formed_frame();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idling(3);
    test_prefix_chars();
    test_empty_frame();
    test_payload_groups();
    test_prefix_inside_group();
    test_unused_op();
    test_random_frames();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL");
    $finish;
  end

endmodule
